### design/lpst_pkg.sv
// lpst_pkg: shared types, constants and CORDIC angle table for the local point
// to screen transform. No dependencies.
`timescale 1ns / 1ps
package lpst_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int COORD_FRAC_BITS = 16;
	localparam int CORDIC_STEPS    = 24;
	localparam int STEP_W          = 5;
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCREEN_PER = 2'd2;
	localparam logic [1:0] REG_PIX_PER_M  = 2'd3;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0]        pose_heading;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} lpst_in_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic               clipped;
	} lpst_out_t;

	// one CORDIC cell's state plus the item payload riding along
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [32:0] z;
		logic [1:0]         quad;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} lpst_cord_t;

	// atan(2^-i) in units of 2^32 per turn
	function automatic logic signed [32:0] atan_lut(input logic [STEP_W-1:0] i);
		logic signed [32:0] r;
		case (i)
			5'd0:  r = 33'sd536870912;
			5'd1:  r = 33'sd316933406;
			5'd2:  r = 33'sd167458907;
			5'd3:  r = 33'sd85004756;
			5'd4:  r = 33'sd42667331;
			5'd5:  r = 33'sd21354465;
			5'd6:  r = 33'sd10679838;
			5'd7:  r = 33'sd5340245;
			5'd8:  r = 33'sd2670163;
			5'd9:  r = 33'sd1335087;
			5'd10: r = 33'sd667544;
			5'd11: r = 33'sd333772;
			5'd12: r = 33'sd166886;
			5'd13: r = 33'sd83443;
			5'd14: r = 33'sd41722;
			5'd15: r = 33'sd20861;
			5'd16: r = 33'sd10430;
			5'd17: r = 33'sd5215;
			5'd18: r = 33'sd2608;
			5'd19: r = 33'sd1304;
			5'd20: r = 33'sd652;
			5'd21: r = 33'sd326;
			5'd22: r = 33'sd163;
			5'd23: r = 33'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/local_point_to_screen_transform_top.sv
// Top level: heading CORDIC cell chain, rigid transform, map and screen scaling.
// Depends on lpst_pkg and lpst_cordic_cell.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  in_data (lpst_in_t)
//   out      out  out_valid/out_stall out_data (lpst_out_t)
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; 24 CORDIC cells, then 8 arithmetic
// stages (products, sum, round, map scale, map offset, map round, screen scale,
// output).
// The whole pipeline freezes while a valid output item is stalled.
// arst_n clears stage valids and loads the register reset values.
`timescale 1ns / 1ps
module local_point_to_screen_transform_top import lpst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  lpst_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output lpst_out_t   out_data,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int NSTAGE = CORDIC_STEPS + 8;
	localparam int MAP_SH = COORD_FRAC_BITS + 16;

	logic [15:0] map_width_q, map_height_q;
	logic [31:0] screen_per_q, pix_per_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 16'd512;
			map_height_q <= 16'd512;
			screen_per_q <= 32'd65536;
			pix_per_m_q  <= 32'd1310720;
		end else if (cfg_we && cfg_index[7:2] == 6'd0) begin
			case (cfg_index[1:0])
				REG_MAP_WIDTH:  map_width_q  <= cfg_data[15:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_data[15:0];
				REG_SCREEN_PER: screen_per_q <= cfg_data;
				REG_PIX_PER_M:  pix_per_m_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic              adv;
	logic [NSTAGE-1:0] vld_q;

	assign adv       = !(vld_q[NSTAGE-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTAGE-2:0], in_valid};
		end
	end

	// CORDIC chain
	lpst_cord_t         cord [0:CORDIC_STEPS];
	logic [31:0]        ang;

	always_comb begin
		ang             = {in_data.pose_heading[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
		cord[0].x       = CORDIC_GAIN;
		cord[0].y       = '0;
		cord[0].z       = {3'b000, ang[29:0]};
		cord[0].quad    = ang[31:30];
		cord[0].pose_x  = in_data.pose_x;
		cord[0].pose_y  = in_data.pose_y;
		cord[0].point_x = in_data.point_x;
		cord[0].point_y = in_data.point_y;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		lpst_cordic_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.step (STEP_W'(i)),
			.d    (cord[i]),
			.q    (cord[i+1])
		);
	end

	// stage 1: quadrant fold and the four rotation products
	lpst_cord_t         cf;
	logic signed [32:0] cs, sn;
	logic signed [64:0] pcx_s1, psy_s1, psx_s1, pcy_s1;
	logic signed [31:0] pose_x_s1, pose_y_s1;

	assign cf = cord[CORDIC_STEPS];

	always_comb begin
		case (cf.quad)
			2'd0: begin cs = cf.x;  sn = cf.y;  end
			2'd1: begin cs = -cf.y; sn = cf.x;  end
			2'd2: begin cs = -cf.x; sn = -cf.y; end
			default: begin cs = cf.y; sn = -cf.x; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pcx_s1    <= cs * cf.point_x;
			psy_s1    <= sn * cf.point_y;
			psx_s1    <= sn * cf.point_x;
			pcy_s1    <= cs * cf.point_y;
			pose_x_s1 <= cf.pose_x;
			pose_y_s1 <= cf.pose_y;
		end
	end

	// stage 2: world sums in Q(F+30)
	logic signed [66:0] gx_s2, gy_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2 <= 67'(pcx_s1) - 67'(psy_s1) + (67'(pose_x_s1) <<< 30);
			gy_s2 <= 67'(psx_s1) + 67'(pcy_s1) + (67'(pose_y_s1) <<< 30);
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -50'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// half away from zero: up when fraction above half, or at half and ip >= 0
	function automatic logic signed [31:0] rnd30(input logic signed [66:0] v);
		logic signed [49:0] ip;
		logic               up;
		ip = 50'(v >>> 30);
		up = v[29] && (v[28:0] != '0 || !ip[49]);
		return sat32(ip + 50'(up));
	endfunction

	// stage 3: round world coordinates to Q(32-F).F
	logic signed [31:0] gx_s3, gy_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s3 <= rnd30(gx_s2);
			gy_s3 <= rnd30(gy_s2);
		end
	end

	// stage 4: scale to map pixels
	logic signed [64:0] mxp_s4, myp_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			mxp_s4 <= gx_s3 * $signed({1'b0, pix_per_m_q});
			myp_s4 <= gy_s3 * $signed({1'b0, pix_per_m_q});
		end
	end

	// stage 5: y flip, half-size offset, odd size carries half a pixel
	logic signed [65:0] nmy;
	logic signed [49:0] ipx, ipy;
	logic [MAP_SH:0]    frx, fry;
	logic signed [49:0] ipx_s5, ipy_s5;
	logic [MAP_SH-1:0]  frx_s5, fry_s5;

	always_comb begin
		nmy = -66'(myp_s4);
		ipx = 50'(mxp_s4 >>> MAP_SH) + 50'(map_width_q >> 1);
		ipy = 50'(nmy >>> MAP_SH) + 50'(map_height_q >> 1);
		frx = {1'b0, mxp_s4[MAP_SH-1:0]} + (map_width_q[0]  ? (MAP_SH+1)'(1) << (MAP_SH-1) : '0);
		fry = {1'b0, nmy[MAP_SH-1:0]}    + (map_height_q[0] ? (MAP_SH+1)'(1) << (MAP_SH-1) : '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ipx_s5 <= ipx + 50'(frx[MAP_SH]);
			ipy_s5 <= ipy + 50'(fry[MAP_SH]);
			frx_s5 <= frx[MAP_SH-1:0];
			fry_s5 <= fry[MAP_SH-1:0];
		end
	end

	// stage 6: round map pixels
	logic signed [31:0] mx_s6, my_s6;
	logic               upx, upy;

	assign upx = frx_s5[MAP_SH-1] && (frx_s5[MAP_SH-2:0] != '0 || !ipx_s5[49]);
	assign upy = fry_s5[MAP_SH-1] && (fry_s5[MAP_SH-2:0] != '0 || !ipy_s5[49]);

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s6 <= sat32(ipx_s5 + 50'(upx));
			my_s6 <= sat32(ipy_s5 + 50'(upy));
		end
	end

	// stage 7: scale to screen pixels
	logic signed [64:0] sxp_s7, syp_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			sxp_s7 <= mx_s6 * $signed({1'b0, screen_per_q});
			syp_s7 <= my_s6 * $signed({1'b0, screen_per_q});
		end
	end

	// stage 8: round, clamp to 16 bits, flag clipping
	logic signed [49:0] vx, vy;
	logic               cxh, cxl, cyh, cyl;

	always_comb begin
		vx  = 50'(sxp_s7 >>> 16) + 50'(sxp_s7[15] && (sxp_s7[14:0] != '0 || !sxp_s7[64]));
		vy  = 50'(syp_s7 >>> 16) + 50'(syp_s7[15] && (syp_s7[14:0] != '0 || !syp_s7[64]));
		cxh = vx > 50'sd32767;
		cxl = vx < -50'sd32768;
		cyh = vy > 50'sd32767;
		cyl = vy < -50'sd32768;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.screen_x <= cxh ? 16'sh7FFF : (cxl ? 16'sh8000 : vx[15:0]);
			out_data.screen_y <= cyh ? 16'sh7FFF : (cyl ? 16'sh8000 : vy[15:0]);
			out_data.clipped  <= cxh || cxl || cyh || cyl;
		end
	end

	// a clip flag always comes with a coordinate pinned at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped |->
			out_data.screen_x == 16'sh7FFF || out_data.screen_x == 16'sh8000 ||
			out_data.screen_y == 16'sh7FFF || out_data.screen_y == 16'sh8000)
		else $error("clipped without saturated coordinate");

	// a stalled output freezes every stage valid
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_q))
		else $error("pipeline moved under output stall");

	// input is refused only while the output item is held
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");
endmodule

### design/lpst_cordic_cell.sv
// lpst_cordic_cell: one CORDIC rotation step with its output register.
// Depends on lpst_pkg.
`timescale 1ns / 1ps
module lpst_cordic_cell import lpst_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  lpst_cord_t        d,
	output lpst_cord_t        q
);
	lpst_cord_t         nxt;
	logic signed [32:0] sx;
	logic signed [32:0] sy;

	always_comb begin
		sx  = d.x >>> step;
		sy  = d.y >>> step;
		nxt = d;
		if (!d.z[32]) begin
			nxt.x = d.x - sy;
			nxt.y = d.y + sx;
			nxt.z = d.z - atan_lut(step);
		end else begin
			nxt.x = d.x + sy;
			nxt.y = d.y - sx;
			nxt.z = d.z + atan_lut(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for local_point_to_screen_transform_top.
// Depends on lpst_pkg and the design files; predicts each screen point in-line.
`timescale 1ns / 1ps
module tb_top;
	import lpst_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int PIPE_LAT     = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	lpst_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	lpst_out_t   out_data;
	logic        cfg_we;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	local_point_to_screen_transform_top dut (.*);

	// predictor copy of the registers
	logic [15:0] map_w, map_h;
	logic [31:0] scr_per_map, px_per_m;

	lpst_out_t screen_q[$];
	int        errors;
	int        cycle_cnt;
	bit        quiet;       // no random idling on either side
	int        hold_left;   // forced receiver hold-off

	const longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	function automatic longint rnd_parts(longint ip, longint unsigned fr, int s);
		longint unsigned half;
		half = 64'd1 << (s - 1);
		if (fr > half) return ip + 1;
		if (fr < half) return ip;
		return (ip >= 0) ? ip + 1 : ip;
	endfunction

	function automatic longint rnd_shr(longint v, int s);
		longint unsigned mask;
		mask = (64'd1 << s) - 1;
		return rnd_parts(v >>> s, longint'(v) & mask, s);
	endfunction

	function automatic longint sat_i32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint map_pixel(longint prod, logic [15:0] dim);
		longint ip;
		longint unsigned fr;
		ip = (prod >>> 32) + longint'(dim >> 1);
		fr = longint'(prod) & 64'hFFFF_FFFF;
		if (dim[0]) begin
			fr += 64'h8000_0000;
			if (fr >= 64'h1_0000_0000) begin
				fr -= 64'h1_0000_0000;
				ip += 1;
			end
		end
		return sat_i32(rnd_parts(ip, fr, 32));
	endfunction

	function automatic logic [15:0] screen_pixel(longint m, inout logic clip);
		longint v;
		v = rnd_shr(m * longint'({32'd0, scr_per_map}), 16);
		if (v > 32767) begin
			clip = 1'b1;
			return 16'h7FFF;
		end
		if (v < -32768) begin
			clip = 1'b1;
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	function automatic lpst_out_t predict_screen(lpst_in_t it);
		logic [31:0] ang;
		longint x, y, z, nx, c, s, gx, gy, mx, my, ppm;
		logic clip;
		lpst_out_t r;
		ang = {it.pose_heading, 16'd0};
		x = 652032874; y = 0; z = longint'(ang[29:0]);
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
			end
			x = nx;
		end
		case (ang[31:30])
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		gx = c * longint'(it.point_x) - s * longint'(it.point_y) + (longint'(it.pose_x) <<< 30);
		gy = s * longint'(it.point_x) + c * longint'(it.point_y) + (longint'(it.pose_y) <<< 30);
		gx = sat_i32(rnd_shr(gx, 30));
		gy = sat_i32(rnd_shr(gy, 30));
		ppm = longint'({32'd0, px_per_m});
		mx = map_pixel(gx * ppm, map_w);
		my = map_pixel(-(gy * ppm), map_h);
		clip = 1'b0;
		r.screen_x = screen_pixel(mx, clip);
		r.screen_y = screen_pixel(my, clip);
		r.clipped = clip;
		return r;
	endfunction

	// receiver: random stalls, forced hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !quiet && ($urandom_range(99) < 38);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (screen_q.size() == 0) begin
				$display("%0t: unexpected item %h", $time, out_data);
				errors++;
			end else begin
				lpst_out_t e;
				e = screen_q.pop_front();
				if (out_data.screen_x !== e.screen_x)
					$display("%0t: screen_x exp %0d got %0d", $time, e.screen_x, out_data.screen_x);
				if (out_data.screen_y !== e.screen_y)
					$display("%0t: screen_y exp %0d got %0d", $time, e.screen_y, out_data.screen_y);
				if (out_data.clipped !== e.clipped)
					$display("%0t: clipped exp %0b got %0b", $time, e.clipped, out_data.clipped);
				if (out_data !== e) errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic send_item(lpst_in_t it);
		if (!quiet && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		screen_q.push_back(predict_screen(it));
	endtask

	// drop valid at the accepting edge of the last item so it is not taken twice
	task automatic drain();
		in_valid <= 1'b0;
		while (screen_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			8'(REG_MAP_WIDTH):  map_w = val[15:0];
			8'(REG_MAP_HEIGHT): map_h = val[15:0];
			8'(REG_SCREEN_PER): scr_per_map = val;
			8'(REG_PIX_PER_M):  px_per_m = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_view(logic [15:0] w, logic [15:0] h, logic [31:0] spm, logic [31:0] ppm);
		write_reg(8'(REG_MAP_WIDTH), {16'd0, w});
		write_reg(8'(REG_MAP_HEIGHT), {16'd0, h});
		write_reg(8'(REG_SCREEN_PER), spm);
		write_reg(8'(REG_PIX_PER_M), ppm);
	endtask

	// mostly within 128 metres either way, sometimes the full range
	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(9))
			0, 1: return $urandom();
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic lpst_in_t rnd_item();
		lpst_in_t it;
		it.pose_x = rnd_coord();
		it.pose_y = rnd_coord();
		it.pose_heading = 16'($urandom_range(16'hFFFF));
		it.point_x = rnd_coord();
		it.point_y = rnd_coord();
		return it;
	endfunction

	task automatic send_random(int n);
		repeat (n) send_item(rnd_item());
	endtask

	task automatic test_directed();
		const logic [15:0] hd[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
			16'h8000, 16'hC000, 16'hFFFF, 16'h1234};
		lpst_in_t it;
		for (int i = 0; i < 8; i++) begin
			it = '{pose_x: 32'sh0001_0000, pose_y: -32'sh0002_8000, pose_heading: hd[i],
				point_x: 32'sh0003_0000, point_y: 32'sh0000_8000};
			send_item(it);
		end
		send_item('0);
		send_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_item('{32'h8000_0000, 32'h8000_0000, 16'h0000, 32'h8000_0000, 32'h8000_0000});
		send_item('{32'h8000_0000, 32'h7FFF_FFFF, 16'h4000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_item('{32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 32'h0000_0001, 32'hFFFF_FFFF});
		// exact map pixel: a half pixel (1/40 m) is not exact, but 0.5 m at 20 px/m lands 10 pixels off centre
		send_item('{32'sh0000_8000, -32'sh0000_8000, 16'h0000, 32'sh0, 32'sh0});
		drain();
	endtask

	task automatic test_view_extremes();
		set_view(16'd1, 16'd1, 32'd0, 32'd1);
		send_random(60);
		drain();
		set_view(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_random(60);
		drain();
		// odd sizes keep the half pixel; stray index must be ignored
		set_view(16'd641, 16'd479, 32'h0000_8000, 32'h0003_0000);
		write_reg(8'd200, $urandom());
		write_reg(8'd4, $urandom());
		send_random(80);
		drain();
	endtask

	task automatic test_backpressure();
		set_view(16'd1024, 16'd768, 32'h0001_8000, 32'h000A_0000);
		quiet = 1'b1;
		hold_left = 300;
		send_random(120);
		quiet = 1'b0;
		drain();
	endtask

	task automatic test_random_views();
		for (int p = 0; p < 6; p++) begin
			set_view(16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(16'hFFFF, 1)),
				$urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000),
				$urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0040_0000, 1));
			if (p == 2) quiet = 1'b1;
			send_random(150);
			quiet = 1'b0;
			drain();
		end
	endtask

	initial begin
		errors = 0; cycle_cnt = 0; quiet = 1'b0; hold_left = 0;
		map_w = 16'd512; map_h = 16'd512; scr_per_map = 32'h0001_0000; px_per_m = 32'h0014_0000;
		arst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_view_extremes();
		test_backpressure();
		test_random_views();
		set_view(16'd512, 16'd512, 32'h0001_0000, 32'h0014_0000);
		send_random(150);
		drain();
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### filelist.f
design/lpst_pkg.sv
design/lpst_cordic_cell.sv
design/local_point_to_screen_transform_top.sv
test/tb_top.sv
